[hw/rtl/oarb_pkg.sv]
// shared constants and types for the overlap-add ring buffer
`timescale 1ns / 1ps

package oarb_pkg;

  localparam int ADDR_W = 12;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam int SAMPLE_W = 16;
  localparam int SHIFT_W  = 13;
  localparam int LEN_W    = 13;
  localparam int SUM_W    = (ADDR_W > SHIFT_W) ? ADDR_W : SHIFT_W;
  localparam int ACC_W    = SAMPLE_W + 1;

  localparam logic signed [ACC_W-1:0] SAT_HIGH = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LOW  = -ACC_W'(32766);
  localparam logic [LEN_W-1:0]        LENGTH_RESET = LEN_W'(400);

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_START = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef logic [ADDR_W-1:0] addr_t;

endpackage

[hw/rtl/overlap_add_ring_buffer.sv]
// overlap-add ring buffer: pointers, accumulate store and result register
`timescale 1ns / 1ps

// Usage
// Input channel: an item transfers at a rising edge with start high and busy low.
// in_action selects read-and-clear, start segment or add sample; the other
// input ports are only looked at by the action that uses them.
// Result channel: every item gives exactly one result, shown for one cycle
// with out_valid high; the receiver cannot stall, so results are never held.
// Path: an accepted item is registered in stage 1 and then in the output stage.
// Throughput: one item per cycle while busy is low; the store has one read and
// one write port, the read of an item and the write-back of the previous one
// share a cycle, and a same-address clash is bypassed from the write-back.
// Reset: pointers go to zero and the recorded length to 400; then a clearing
// pass writes zero to all 4096 entries, one a cycle, and busy stays high until
// the pass is done, before the first item can transfer.
module overlap_add_ring_buffer
  import oarb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_action,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic signed [SHIFT_W-1:0]  in_start_shift,
  input  logic [LEN_W-1:0]           in_segment_length,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_caught_up,
  output logic [LEN_W-1:0]           out_last_length
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // control state
  logic       clearing_r;
  addr_t      clr_cnt_r;
  addr_t      rp_r, rp_nxt;
  addr_t      ssp_r, ssp_nxt;
  addr_t      wp_r, wp_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  // stage 1
  logic       s1_valid_r;
  action_t    s1_action_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  addr_t      s1_addr_r;
  logic       s1_caught_r;
  logic [LEN_W-1:0] s1_len_r;
  logic       fwd_hit_r;
  logic signed [SAMPLE_W-1:0] fwd_data_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;

  // output stage
  logic       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic       out_caught_r;
  logic [LEN_W-1:0] out_len_r;

  logic       accept;
  action_t    act;
  addr_t      acc_addr;
  logic [SUM_W-1:0] pos_sum;
  logic signed [SAMPLE_W-1:0] old_val;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] wb_val;
  logic       wb_en;
  logic       mem_we;
  addr_t      mem_wa;
  logic signed [SAMPLE_W-1:0] mem_wd;
  logic signed [SAMPLE_W-1:0] res_sample;

  assign busy   = clearing_r;
  assign accept = start && !clearing_r;
  assign act    = action_t'(in_action);

  // pointer update for the item being transferred
  always_comb begin
    rp_nxt   = rp_r;
    ssp_nxt  = ssp_r;
    wp_nxt   = wp_r;
    len_nxt  = len_r;
    acc_addr = rp_r;
    pos_sum  = SUM_W'(ssp_r) + SUM_W'(in_start_shift);
    if (accept) begin
      unique case (act)
        ACT_READ: begin
          acc_addr = rp_r;
          rp_nxt   = rp_r + ADDR_W'(1);
        end
        ACT_START: begin
          ssp_nxt = pos_sum[ADDR_W-1:0];
          wp_nxt  = pos_sum[ADDR_W-1:0];
          len_nxt = in_segment_length;
        end
        ACT_ADD: begin
          acc_addr = wp_r;
          wp_nxt   = wp_r + ADDR_W'(1);
        end
        ACT_NONE: begin
          acc_addr = rp_r;
        end
        default: begin
          acc_addr = rp_r;
        end
      endcase
    end
  end

  // read-modify-write of stage 1
  always_comb begin
    old_val = fwd_hit_r ? fwd_data_r : rd_data_r;
    acc_sum = ACC_W'(old_val) + ACC_W'(s1_sample_r);
    wb_val  = '0;
    wb_en   = 1'b0;
    res_sample = '0;
    if (s1_valid_r) begin
      unique case (s1_action_r)
        ACT_READ: begin
          wb_en      = 1'b1;
          wb_val     = '0;
          res_sample = old_val;
        end
        ACT_ADD: begin
          wb_en = 1'b1;
          priority if (acc_sum > SAT_HIGH) begin
            wb_val = SAMPLE_W'(SAT_HIGH);
          end else if (acc_sum < SAT_LOW) begin
            wb_val = SAMPLE_W'(SAT_LOW);
          end else begin
            wb_val = acc_sum[SAMPLE_W-1:0];
          end
        end
        ACT_START, ACT_NONE: begin
          wb_en = 1'b0;
        end
        default: begin
          wb_en = 1'b0;
        end
      endcase
    end
  end

  // write port shared by clearing pass and write-back
  always_comb begin
    if (clearing_r) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else begin
      mem_we = wb_en;
      mem_wa = s1_addr_r;
      mem_wd = wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      rp_r        <= '0;
      ssp_r       <= '0;
      wp_r        <= '0;
      len_r       <= LENGTH_RESET;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      rp_r        <= rp_nxt;
      ssp_r       <= ssp_nxt;
      wp_r        <= wp_nxt;
      len_r       <= len_nxt;
      s1_valid_r  <= accept;
      fwd_hit_r   <= wb_en && (s1_addr_r == acc_addr);
      out_valid_r <= s1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fwd_data_r   <= wb_val;
    s1_action_r  <= act;
    s1_sample_r  <= in_sample_in;
    s1_addr_r    <= acc_addr;
    s1_caught_r  <= (rp_nxt == ssp_nxt);
    s1_len_r     <= len_nxt;
    out_sample_r <= res_sample;
    out_caught_r <= s1_caught_r;
    out_len_r    <= s1_len_r;
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_caught_up   = out_caught_r;
  assign out_last_length = out_len_r;

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the overlap-add ring buffer
`timescale 1ns / 1ps

module tb_top;
  import oarb_pkg::*;

  typedef struct packed {
    action_t                     act;
    logic signed [SAMPLE_W-1:0]  value;
    logic signed [SHIFT_W-1:0]   shift;
    logic [LEN_W-1:0]            seg_len;
  } ola_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  value;
    logic                        caught;
    logic [LEN_W-1:0]            length;
  } ola_result_t;

  typedef struct packed {
    ola_item_t   it;
    logic        fixed;
    ola_result_t want;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [1:0]                 in_action = '0;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic signed [SHIFT_W-1:0]  in_start_shift = '0;
  logic [LEN_W-1:0]           in_segment_length = '0;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_caught_up;
  logic [LEN_W-1:0]           out_last_length;

  logic        fixed_valid = 1'b0;
  ola_result_t fixed_res = '0;

  overlap_add_ring_buffer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_sample_in      (in_sample_in),
    .in_start_shift    (in_start_shift),
    .in_segment_length (in_segment_length),
    .out_valid         (out_valid),
    .out_sample_out    (out_sample_out),
    .out_caught_up     (out_caught_up),
    .out_last_length   (out_last_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // accumulation model state
  logic signed [SAMPLE_W-1:0] ola_store [DEPTH];
  addr_t                      ola_rd, ola_ss, ola_wr;
  logic [LEN_W-1:0]           ola_len;

  ola_result_t pending_results [$];
  stim_row_t   directed_rows [$];

  int unsigned n_bad = 0;
  int unsigned n_results = 0;
  int unsigned n_sent = 0;
  int unsigned n_reads = 0;
  int unsigned n_adds = 0;
  int unsigned n_starts = 0;
  int unsigned n_unused = 0;
  int unsigned n_sat = 0;
  int unsigned n_caught = 0;
  int unsigned n_rd_wraps = 0;
  int unsigned n_wr_wraps = 0;

  function automatic ola_result_t ola_apply(ola_item_t it);
    ola_result_t r;
    int          pos;
    int          sum;
    r.value = '0;
    case (it.act)
      ACT_READ: begin
        r.value = ola_store[ola_rd];
        ola_store[ola_rd] = '0;
        if (ola_rd == addr_t'(DEPTH - 1)) n_rd_wraps++;
        ola_rd = ola_rd + 1'b1;
        n_reads++;
      end
      ACT_START: begin
        pos = (int'(ola_ss) + int'($signed(it.shift))) % DEPTH;
        if (pos < 0) pos += DEPTH;
        ola_ss = addr_t'(pos);
        ola_wr = ola_ss;
        ola_len = it.seg_len;
        n_starts++;
      end
      ACT_ADD: begin
        sum = int'(ola_store[ola_wr]) + int'($signed(it.value));
        if (sum > int'(SAT_HIGH)) begin
          sum = int'(SAT_HIGH);
          n_sat++;
        end
        if (sum < int'(SAT_LOW)) begin
          sum = int'(SAT_LOW);
          n_sat++;
        end
        ola_store[ola_wr] = SAMPLE_W'(sum);
        if (ola_wr == addr_t'(DEPTH - 1)) n_wr_wraps++;
        ola_wr = ola_wr + 1'b1;
        n_adds++;
      end
      default: begin
        n_unused++;
      end
    endcase
    r.caught = (ola_rd == ola_ss);
    r.length = ola_len;
    if (r.caught) n_caught++;
    return r;
  endfunction

  // compare results against the oldest expectation, then log new transfers
  always @(posedge clk) begin
    ola_result_t got;
    ola_result_t want;
    ola_item_t   it;
    if (rst_n) begin
      if (out_valid) begin
        n_results++;
        got.value  = out_sample_out;
        got.caught = out_caught_up;
        got.length = out_last_length;
        if (pending_results.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result %0d: sample %0d caught %0b length %0d",
                     n_results, got.value, got.caught, got.length);
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value || got.caught !== want.caught ||
              got.length !== want.length) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch %0d: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                       n_results, want.value, want.caught, want.length,
                       got.value, got.caught, got.length);
          end
        end
      end
      if (start && !busy) begin
        it.act     = action_t'(in_action);
        it.value   = in_sample_in;
        it.shift   = in_start_shift;
        it.seg_len = in_segment_length;
        want = ola_apply(it);
        if (fixed_valid) want = fixed_res;
        pending_results.push_back(want);
      end
    end
  end

  task automatic send(input ola_item_t it, input int unsigned idle_pct,
                      input logic fixed = 1'b0, input ola_result_t want = '0);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    in_action         <= it.act;
    in_sample_in      <= it.value;
    in_start_shift    <= it.shift;
    in_segment_length <= it.seg_len;
    fixed_valid       <= fixed;
    fixed_res         <= want;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [SHIFT_W-1:0] rand_shift();
    return SHIFT_W'(int'($urandom_range(8190)) - 4095);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_W'(32767 - int'($urandom_range(15)));
      1: return SAMPLE_W'(-32768 + int'($urandom_range(15)));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // random values in every port, including those the action ignores
  function automatic ola_item_t junk_item(action_t a);
    ola_item_t it;
    it.act     = a;
    it.value   = pick_sample();
    it.shift   = rand_shift();
    it.seg_len = LEN_W'($urandom);
    return it;
  endfunction

  task automatic add_row(input action_t a, input int v, input int sh, input int len,
                         input logic fixed = 1'b0, input int ev = 0, input logic ec = 1'b0,
                         input int el = 0);
    stim_row_t row;
    row.it.act      = a;
    row.it.value    = SAMPLE_W'(v);
    row.it.shift    = SHIFT_W'(sh);
    row.it.seg_len  = LEN_W'(len);
    row.fixed       = fixed;
    row.want.value  = SAMPLE_W'(ev);
    row.want.caught = ec;
    row.want.length = LEN_W'(el);
    directed_rows.push_back(row);
  endtask

  // one pitch period: start, add the segment, read out the shift (or a random count if it is not 1 to 24)
  task automatic run_segment(input int unsigned idle_pct);
    int unsigned n_add;
    int unsigned n_rd;
    int          sh;
    ola_item_t   it;
    n_add = $urandom_range(40);
    if ($urandom_range(9) == 0) sh = int'($signed(rand_shift()));
    else sh = $urandom_range(24);
    it = junk_item(ACT_START);
    it.shift = SHIFT_W'(sh);
    it.seg_len = ($urandom_range(7) == 0) ? LEN_W'($urandom) : LEN_W'(n_add);
    send(it, idle_pct);
    repeat (n_add) send(junk_item(ACT_ADD), idle_pct);
    n_rd = (sh > 0 && sh <= 24) ? sh : $urandom_range(24);
    repeat (n_rd) send(junk_item(ACT_READ), idle_pct);
  endtask

  task automatic run_phase(input int unsigned target, input int unsigned idle_pct);
    int unsigned first;
    first = n_sent;
    while (n_sent - first < target) begin
      if ($urandom_range(99) < 15) send(junk_item(action_t'($urandom_range(3))), idle_pct);
      else run_segment(idle_pct);
    end
    drain();
  endtask

  initial begin
    for (int k = 0; k < DEPTH; k++) ola_store[k] = '0;
    ola_rd  = '0;
    ola_ss  = '0;
    ola_wr  = '0;
    ola_len = LENGTH_RESET;

    // action, sample, shift, length, typed expectation: sample, caught, length
    add_row(ACT_READ,  0,      0,     0,    1'b1, 0,      1'b0, LENGTH_RESET);
    add_row(ACT_NONE,  -1,     -1,    8191, 1'b1, 0,      1'b0, LENGTH_RESET);
    add_row(ACT_START, 0,      1,     0,    1'b1, 0,      1'b1, 0);
    add_row(ACT_ADD,   32767,  0,     0,    1'b1, 0,      1'b1, 0);
    add_row(ACT_ADD,   1,      0,     0,    1'b1, 0,      1'b1, 0);
    add_row(ACT_START, 0,      0,     4096, 1'b1, 0,      1'b1, 4096);
    add_row(ACT_ADD,   32767,  0,     0,    1'b1, 0,      1'b1, 4096);
    add_row(ACT_ADD,   -32768, 0,     0,    1'b1, 0,      1'b1, 4096);
    add_row(ACT_READ,  0,      0,     0,    1'b1, 32767,  1'b0, 4096);
    add_row(ACT_READ,  0,      0,     0,    1'b1, -32766, 1'b0, 4096);
    add_row(ACT_READ,  0,      0,     0);
    add_row(ACT_START, 0,      -4095, 8191, 1'b1, 0,      1'b0, 8191);
    // negative wrap to the top of the ring, then adds across the end
    add_row(ACT_START, 0,      -4,    3);
    add_row(ACT_ADD,   -32768, 0,     0);
    add_row(ACT_ADD,   100,    0,     0);
    add_row(ACT_ADD,   -100,   0,     0);
    add_row(ACT_START, 0,      4095,  4096);
    add_row(ACT_START, 0,      7,     0);
    // add then read of the same entry, back to back unless random idles fall between
    add_row(ACT_ADD,   32767,  -1,    8191);
    add_row(ACT_READ,  -32768, 4095,  8191);
    add_row(ACT_NONE,  32767,  4095,  4096);
    add_row(ACT_START, 0,      1,     5);
    add_row(ACT_READ,  0,      0,     0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send(directed_rows[i].it, 26, directed_rows[i].fixed, directed_rows[i].want);
    drain();

    run_phase(570, 26);
    run_phase(570, 70);
    run_phase(560, 0);

    repeat (8) @(negedge clk);

    $display("covered %0d transfers: %0d reads, %0d adds, %0d starts, %0d unused codes",
             n_sent, n_reads, n_adds, n_starts, n_unused);
    $display("%0d saturating adds, %0d caught-up results, %0d read and %0d write wraps",
             n_sat, n_caught, n_rd_wraps, n_wr_wraps);
    if (n_bad == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d bad results", n_bad);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
